@@ sv/tsm_pkg.sv @@
// Package for the timestamp stream merger: head record, chain candidate,
// cell control bundle, controller states and the event ordering function.
// No dependencies; the top, the cell and the controller import it.
package tsm_pkg;

   // Source index width inside the cell chain; covers up to 16 sources
   localparam int SRC_IDX_W = 4;
   // Width of the source enable mask; only sources 0 to 3 can be enabled
   localparam int ENABLE_W  = 4;
   // Most results that one accepted item may cause during a flush
   localparam logic [1:0] FLUSH_MAX = 2'd3;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SCAN
   } tsm_state_type;

   // One pending head event
   typedef struct packed {
      logic signed [63:0] time_stamp;
      logic [1:0]         kind;
      logic [31:0]        sequence_req;
      logic signed [31:0] security;
      logic [63:0]        price_bits;
      logic signed [31:0] quantity;
   } tsm_head_type;

   // Running best head handed from cell to cell
   typedef struct packed {
      logic                 valid;
      logic [SRC_IDX_W-1:0] idx;
      tsm_head_type         head;
   } tsm_cand_type;

   // Controller to cell strobes
   typedef struct packed {
      logic                 accept;
      logic                 func;
      logic [1:0]           src;
      logic                 clear;
      logic [SRC_IDX_W-1:0] clear_idx;
   } tsm_cell_ctl_type;

   // True when head a orders strictly before head b: signed time, kind, sequence
   function automatic logic head_before(tsm_head_type a, tsm_head_type b);
      logic [97:0] key_a;
      logic [97:0] key_b;
      key_a = {~a.time_stamp[63], a.time_stamp[62:0], a.kind, a.sequence_req};
      key_b = {~b.time_stamp[63], b.time_stamp[62:0], b.kind, b.sequence_req};
      return key_a < key_b;
   endfunction

endpackage

@@ sv/tsm_if.sv @@
// Stream channel interfaces of the timestamp stream merger: the event/end-of-stream
// request channel and the merged result channel. No dependencies.

interface tsm_req_if;
   logic               valid;
   logic               ready;
   logic               func;
   logic [1:0]         source_index;
   logic signed [63:0] time_stamp;
   logic [1:0]         kind;
   logic [31:0]        sequence_req;
   logic signed [31:0] security;
   logic [63:0]        price_bits;
   logic signed [31:0] quantity;

   modport source (
      output valid, func, source_index, time_stamp, kind, sequence_req, security,
             price_bits, quantity,
      input  ready
   );
   modport sink (
      input  valid, func, source_index, time_stamp, kind, sequence_req, security,
             price_bits, quantity,
      output ready
   );
endinterface

interface tsm_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         out_source;
   logic signed [63:0] out_time;
   logic [1:0]         out_kind;
   logic [31:0]        out_sequence;
   logic signed [31:0] out_security;
   logic [63:0]        out_price_bits;
   logic signed [31:0] out_quantity;
   logic               burst_last;

   modport source (
      output valid, out_source, out_time, out_kind, out_sequence, out_security,
             out_price_bits, out_quantity, burst_last,
      input  ready
   );
   modport sink (
      input  valid, out_source, out_time, out_kind, out_sequence, out_security,
             out_price_bits, out_quantity, burst_last,
      output ready
   );
endinterface

@@ sv/timestamp_stream_merger_top.sv @@
// A request transfer starts a scan: the candidate walks the cell chain, one cell per cycle,
// and the winning head is then loaded into the output register. No new item is taken
// until the controller is idle again, and a full output register that is not read holds
// the emit. A flush may emit up to three results per item, each after its own walk.
// Reset (synchronous, active high): slots empty, no source finished, all four enabled;
// no clearing pass.
module timestamp_stream_merger_top #(
   parameter int SOURCES = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   tsm_req_if.sink                      req_if,
   tsm_rsp_if.source                    rsp_if,
   input  logic                         csr_we,
   input  logic [tsm_pkg::ENABLE_W-1:0] csr_wdata
);
   import tsm_pkg::*;

   tsm_cell_ctl_type   ctl;
   tsm_head_type       head_in;
   tsm_cand_type       cand [SOURCES+1];
   logic [SOURCES-1:0] valid_vec;
   logic [SOURCES-1:0] fin_vec;
   logic [SOURCES-1:0] en_vec;

   // Gather the incoming event payload
   always_comb begin
      head_in.time_stamp   = req_if.time_stamp;
      head_in.kind         = req_if.kind;
      head_in.sequence_req = req_if.sequence_req;
      head_in.security     = req_if.security;
      head_in.price_bits   = req_if.price_bits;
      head_in.quantity     = req_if.quantity;
   end

   // Chain starts with no candidate
   assign cand[0] = '0;

   for (genvar g = 0; g < SOURCES; g++) begin : g_cell
      tsm_cell #(
         .CELL_ID (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en_vec[g]),
         .ctl       (ctl),
         .head_in   (head_in),
         .cand_in   (cand[g]),
         .cand_out  (cand[g+1]),
         .valid_out (valid_vec[g]),
         .fin_out   (fin_vec[g])
      );
   end

   tsm_ctrl #(
      .SOURCES (SOURCES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .valid_vec (valid_vec),
      .fin_vec   (fin_vec),
      .tail      (cand[SOURCES]),
      .en_vec    (en_vec),
      .ctl       (ctl)
   );

endmodule

@@ sv/tsm_cell.sv @@
// One source slot of the merger chain: holds the head event and its valid and
// finished flags, and passes on the better of its head and the incoming candidate.
// Depends on tsm_pkg.
module tsm_cell #(
   parameter int CELL_ID = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  tsm_pkg::tsm_cell_ctl_type ctl,
   input  tsm_pkg::tsm_head_type     head_in,
   input  tsm_pkg::tsm_cand_type     cand_in,
   output tsm_pkg::tsm_cand_type     cand_out,
   output logic                      valid_out,
   output logic                      fin_out
);
   import tsm_pkg::*;

   localparam logic [SRC_IDX_W-1:0] CELL_IDX = SRC_IDX_W'(CELL_ID);

   tsm_head_type head_ff;
   logic         valid_ff;
   logic         fin_ff;
   tsm_cand_type cand_ff;
   tsm_cand_type cand_in_mux;
   logic         match;
   logic         load;
   logic         finish;
   logic         own_first;

   // Decode the transfer addressed to this slot
   assign match  = (CELL_ID < 4) && (ctl.src == 2'(CELL_ID));
   assign load   = ctl.accept && !ctl.func && match && en && !fin_ff && !valid_ff;
   assign finish = ctl.accept && ctl.func && match;

   // Hold the head payload
   always_ff @(posedge clock) begin
      if (load) begin
         head_ff <= head_in;
      end
   end

   // Track slot occupancy and end of stream
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         fin_ff   <= 1'b0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
         end else if (ctl.clear && ctl.clear_idx == CELL_IDX) begin
            valid_ff <= 1'b0;
         end
         if (finish) begin
            fin_ff <= 1'b1;
         end
      end
   end

   // Keep the earlier head; an exact tie stays with the lower source upstream
   always_comb begin
      own_first   = valid_ff && (!cand_in.valid || head_before(head_ff, cand_in.head));
      cand_in_mux = cand_in;
      if (own_first) begin
         cand_in_mux.valid = 1'b1;
         cand_in_mux.idx   = CELL_IDX;
         cand_in_mux.head  = head_ff;
      end
   end

   // Advance the candidate one cell per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff.valid <= 1'b0;
      end else begin
         cand_ff.valid <= cand_in_mux.valid;
      end
      cand_ff.idx  <= cand_in_mux.idx;
      cand_ff.head <= cand_in_mux.head;
   end

   assign cand_out  = cand_ff;
   assign valid_out = valid_ff;
   assign fin_out   = fin_ff;

   // A slot is only ever cleared after it was chosen, so it must be full
   a_clear_full: assert property (@(posedge clock) disable iff (reset)
      (ctl.clear && ctl.clear_idx == CELL_IDX) |-> valid_ff)
      else $error("cleared an empty head slot");

   // End of stream is sticky until reset
   a_fin_sticky: assert property (@(posedge clock) disable iff (reset)
      fin_ff |=> fin_ff)
      else $error("finished flag dropped");

endmodule

@@ sv/tsm_ctrl.sv @@
// Sequencer of the merger: takes request transfers, waits for the cell chain to
// settle, decides emit or flush, clears the winning slot and holds the result.
// Depends on tsm_pkg and the tsm_req_if / tsm_rsp_if interfaces.
module tsm_ctrl #(
   parameter int SOURCES = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   tsm_req_if.sink                          req_if,
   tsm_rsp_if.source                        rsp_if,
   input  logic                             csr_we,
   input  logic [tsm_pkg::ENABLE_W-1:0]     csr_wdata,
   input  logic [SOURCES-1:0]               valid_vec,
   input  logic [SOURCES-1:0]               fin_vec,
   input  tsm_pkg::tsm_cand_type            tail,
   output logic [SOURCES-1:0]               en_vec,
   output tsm_pkg::tsm_cell_ctl_type        ctl
);
   import tsm_pkg::*;

   localparam int CNT_W = $clog2(SOURCES + 1);

   tsm_state_type        state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [1:0]           emit_cnt_ff, emit_cnt_in;
   logic [ENABLE_W-1:0]  enable_ff;
   logic                 rsp_valid_ff;
   tsm_cand_type         rsp_data_ff;
   logic                 rsp_last_ff;

   logic                 accept;
   logic                 all_done;
   logic                 ready_all;
   logic                 scan_done;
   logic                 may_emit;
   logic                 want;
   logic                 out_free;
   logic                 fire;
   logic                 more;
   logic [SOURCES-1:0]   win_mask;

   assign accept = req_if.valid && req_if.ready;

   // Per-source enable and winner mask; sources 4 and up are never enabled
   always_comb begin
      for (int i = 0; i < SOURCES; i++) begin
         win_mask[i] = (tail.idx == SRC_IDX_W'(i));
         en_vec[i]   = (i < ENABLE_W) ? enable_ff[2'(i)] : 1'b0;
      end
   end

   // Emit decision once the chain tail reflects every slot
   always_comb begin
      all_done  = ~|(en_vec & ~fin_vec);
      ready_all = ~|(en_vec & ~fin_vec & ~valid_vec);
      scan_done = (state_ff == ST_SCAN) && (cnt_ff == CNT_W'(SOURCES));
      may_emit  = all_done ? (emit_cnt_ff != FLUSH_MAX)
                           : (ready_all && emit_cnt_ff == 2'd0);
      want      = scan_done && may_emit && tail.valid;
      out_free  = !rsp_valid_ff || rsp_if.ready;
      fire      = want && out_free;
      more      = all_done && (emit_cnt_ff < FLUSH_MAX - 2'd1) && |(valid_vec & ~win_mask);
   end

   // Next state
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      emit_cnt_in = emit_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in    = ST_SCAN;
               cnt_in      = '0;
               emit_cnt_in = 2'd0;
            end
         end
         ST_SCAN: begin
            if (!scan_done) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end else if (want) begin
               if (fire) begin
                  if (more) begin
                     cnt_in      = '0;
                     emit_cnt_in = emit_cnt_ff + 2'd1;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs to the cells and the request channel; refuse transfers during reset
   always_comb begin
      req_if.ready  = (state_ff == ST_IDLE) && !reset;
      ctl.accept    = accept;
      ctl.func      = req_if.func;
      ctl.src       = req_if.source_index;
      ctl.clear     = fire;
      ctl.clear_idx = tail.idx;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cnt_ff      <= '0;
         emit_cnt_ff <= 2'd0;
         enable_ff   <= '1;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         emit_cnt_ff <= emit_cnt_in;
         if (csr_we) begin
            enable_ff <= csr_wdata;
         end
      end
   end

   // Result register: load on emit, drop once the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= tail;
         rsp_last_ff <= !more;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.out_source     = rsp_data_ff.idx[1:0];
   assign rsp_if.out_time       = rsp_data_ff.head.time_stamp;
   assign rsp_if.out_kind       = rsp_data_ff.head.kind;
   assign rsp_if.out_sequence   = rsp_data_ff.head.sequence_req;
   assign rsp_if.out_security   = rsp_data_ff.head.security;
   assign rsp_if.out_price_bits = rsp_data_ff.head.price_bits;
   assign rsp_if.out_quantity   = rsp_data_ff.head.quantity;
   assign rsp_if.burst_last     = rsp_last_ff;

   // After a full pass the tail holds a head exactly when some slot is full
   a_tail_any: assert property (@(posedge clock) disable iff (reset)
      scan_done |-> (tail.valid == (|valid_vec)))
      else $error("chain tail disagrees with slot occupancy");

   // An emit shows up in the result register with the winning source
   a_emit_lands: assert property (@(posedge clock) disable iff (reset)
      fire |=> (rsp_if.valid && rsp_if.out_source == $past(tail.idx[1:0])))
      else $error("emitted head missing from result register");

   // Only a flush may emit more than once per item
   a_single_emit: assert property (@(posedge clock) disable iff (reset)
      (fire && !all_done) |-> (emit_cnt_ff == 2'd0))
      else $error("second emit outside a flush");

endmodule
